// File: hw/rtl/sngrf_pkg.sv
// ----------------------------------------------------------------------------
// sngrf_pkg
// Shared constants and types of the sequence number gap replay filter:
// field widths, configuration reset value and the codes of the shared adder.
// ----------------------------------------------------------------------------
package sngrf_pkg;

   localparam int SEQ_W     = 16;
   localparam int EXT_W     = 64;
   localparam int GAPS_DFLT = 8;

   localparam logic [SEQ_W-1:0] THRESHOLD_RESET = 16'd500;
   localparam logic [EXT_W-1:0] SEQ_SPAN        = 64'h0000_0000_0001_0000;
   localparam logic [EXT_W-1:0] SPAN_MASK       = 64'hFFFF_FFFF_FFFF_0000;

   // Operation codes of the shared adder.
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   typedef struct packed {
      logic             op;
      logic [EXT_W-1:0] a;
      logic [EXT_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [EXT_W-1:0] res;
      logic             lt;
   } alu_rsp_type;

endpackage

// File: hw/rtl/sngrf_ram.sv
// ----------------------------------------------------------------------------
// sngrf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sngrf_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/sngrf_alu.sv
// ----------------------------------------------------------------------------
// sngrf_alu
// Shared 64-bit adder. It adds or subtracts; on a subtract the borrow out
// gives the unsigned less-than of the two operands.
// ----------------------------------------------------------------------------
module sngrf_alu (
   input  sngrf_pkg::alu_req_type req,
   output sngrf_pkg::alu_rsp_type rsp
);

   logic [sngrf_pkg::EXT_W:0]   sum;
   logic [sngrf_pkg::EXT_W-1:0] b_op;

   // One carry chain serves both operations: a - b is a + ~b + 1.
   always_comb begin
      b_op = (req.op == sngrf_pkg::ALU_SUB) ? ~req.b : req.b;
      sum  = {1'b0, req.a} + {1'b0, b_op}
           + {{sngrf_pkg::EXT_W{1'b0}}, (req.op == sngrf_pkg::ALU_SUB)};
      rsp.res = sum[sngrf_pkg::EXT_W-1:0];
      rsp.lt  = (req.op == sngrf_pkg::ALU_SUB) && !sum[sngrf_pkg::EXT_W];
   end

endmodule

// File: hw/rtl/seq_number_gap_replay_filter_unit.sv
// ----------------------------------------------------------------------------
// seq_number_gap_replay_filter_unit
// Duplicate filter for 16-bit sequence numbers on two channels. Each number
// is extended to 64 bits against the channel's highest value; newer numbers
// are accepted and skipped ranges kept as gaps, older numbers are accepted
// only when they fall into a recorded gap, which is then shrunk or split.
//
//   Port group   Direction  Handshake          Contents
//   req_*        in         valid / stall      channel, seq_nr
//   rsp_*        out        valid / stall      accepted, extended_seq
//   csr_*        in         write enable       jump_threshold
//
// When an older number splits a gap that it hits, one pass over the slots
// finds the gap and a second pass picks the victim. Every step goes through
// the one shared 64-bit adder and the gap RAM is read one slot at a time.
// req_stall is high from acceptance until the result sits in the output
// register. A stalled result holds the block only when the next result is
// ready to go. Reset is synchronous and clears the highest values and all
// gap slots at once.
// ----------------------------------------------------------------------------
module seq_number_gap_replay_filter_unit #(
   parameter int GAPS_PER_CHANNEL = sngrf_pkg::GAPS_DFLT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_channel,
   input  logic [sngrf_pkg::SEQ_W-1:0]   req_seq_nr,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic [sngrf_pkg::EXT_W-1:0]   rsp_extended_seq,
   input  logic                          csr_we,
   input  logic [sngrf_pkg::SEQ_W-1:0]   csr_wdata
);

   localparam int DEPTH = 2 * GAPS_PER_CHANNEL;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (GAPS_PER_CHANNEL > 1) ? $clog2(GAPS_PER_CHANNEL) : 1;
   localparam int EW    = sngrf_pkg::EXT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(GAPS_PER_CHANNEL - 1);
   localparam logic [AW-1:0] CH1_BASE = AW'(GAPS_PER_CHANNEL);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_E1     = 5'd1;
   localparam logic [4:0] ST_E2     = 5'd2;
   localparam logic [4:0] ST_E3     = 5'd3;
   localparam logic [4:0] ST_E4     = 5'd4;
   localparam logic [4:0] ST_E5     = 5'd5;
   localparam logic [4:0] ST_C1     = 5'd6;
   localparam logic [4:0] ST_C2     = 5'd7;
   localparam logic [4:0] ST_C3     = 5'd8;
   localparam logic [4:0] ST_C4     = 5'd9;
   localparam logic [4:0] ST_C5     = 5'd10;
   localparam logic [4:0] ST_P_RD   = 5'd11;
   localparam logic [4:0] ST_P_CK   = 5'd12;
   localparam logic [4:0] ST_P_CMP  = 5'd13;
   localparam logic [4:0] ST_P_DONE = 5'd14;
   localparam logic [4:0] ST_W2     = 5'd15;
   localparam logic [4:0] ST_S_RD   = 5'd16;
   localparam logic [4:0] ST_S_CK1  = 5'd17;
   localparam logic [4:0] ST_S_CK2  = 5'd18;
   localparam logic [4:0] ST_H1     = 5'd19;
   localparam logic [4:0] ST_H2     = 5'd20;
   localparam logic [4:0] ST_OUT    = 5'd21;

   logic [4:0]                  state_ff, state_in;
   logic                        ch_ff, ch_in;
   logic [sngrf_pkg::SEQ_W-1:0] seq_ff, seq_in;
   logic [EW-1:0]               top_ff, top_in;
   logic [EW-1:0]               diff_ff, diff_in;
   logic                        ge_ff, ge_in;
   logic [EW-1:0]               floor_ff, floor_in;
   logic [EW-1:0]               g_ff, g_in;
   logic [EW-1:0]               top1_ff, top1_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic [IW-1:0]               pick_ff, pick_in;
   logic [IW-1:0]               hit_ff, hit_in;
   logic [EW-1:0]               best_ff, best_in;
   logic [EW-1:0]               cost_ff, cost_in;
   logic [EW-1:0]               hstart_ff, hstart_in;
   logic [EW-1:0]               hend_ff, hend_in;
   logic [EW-1:0]               gx1_ff, gx1_in;
   logic                        split_ff, split_in;
   logic                        newer_ff, newer_in;
   logic                        ok_ff, ok_in;
   logic [EW-1:0]               highest_ff [2];
   logic [EW-1:0]               highest_in [2];
   logic [sngrf_pkg::SEQ_W-1:0] thr_ff, thr_in;
   logic [DEPTH-1:0]            valid_ff, valid_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_acc_ff, rsp_acc_in;
   logic [EW-1:0]               rsp_ext_ff, rsp_ext_in;

   sngrf_pkg::alu_req_type alu_req;
   sngrf_pkg::alu_rsp_type alu_rsp;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [2*EW-1:0]   ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [2*EW-1:0]   ram_rdata;
   logic [EW-1:0]     rd_start;
   logic [EW-1:0]     rd_end;
   logic [EW-1:0]     seq64;
   logic [EW-1:0]     thr64;
   logic [EW-1:0]     top_min;
   logic              req_xfer;
   logic              out_load;
   logic [AW-1:0]     ch_base;

   sngrf_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   sngrf_ram #(
      .WIDTH (2 * EW),
      .DEPTH (DEPTH)
   ) u_gap_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_xfer = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign seq64   = {{(EW - sngrf_pkg::SEQ_W){1'b0}}, seq_ff};
   assign thr64   = {{(EW - sngrf_pkg::SEQ_W){1'b0}}, thr_ff};
   assign top_min = (top_ff < thr64) ? top_ff : thr64;
   assign ch_base = ch_ff ? CH1_BASE : '0;
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // A slot that was never written since its last clear reads as empty.
   assign rd_start = rd_valid_ff ? ram_rdata[2*EW-1:EW] : '0;
   assign rd_end   = rd_valid_ff ? ram_rdata[EW-1:0]    : '0;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_extended_seq = rsp_ext_ff;

   // Sequencer: drives the shared adder, the gap RAM and every next value.
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      seq_in        = seq_ff;
      top_in        = top_ff;
      diff_in       = diff_ff;
      ge_in         = ge_ff;
      floor_in      = floor_ff;
      g_in          = g_ff;
      top1_in       = top1_ff;
      idx_in        = idx_ff;
      pick_in       = pick_ff;
      hit_in        = hit_ff;
      best_in       = best_ff;
      cost_in       = cost_ff;
      hstart_in     = hstart_ff;
      hend_in       = hend_ff;
      gx1_in        = gx1_ff;
      split_in      = split_ff;
      newer_in      = newer_ff;
      ok_in         = ok_ff;
      highest_in[0] = highest_ff[0];
      highest_in[1] = highest_ff[1];
      thr_in        = csr_we ? csr_wdata : thr_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_acc_in    = rsp_acc_ff;
      rsp_ext_in    = rsp_ext_ff;
      alu_req.op    = sngrf_pkg::ALU_SUB;
      alu_req.a     = top_ff;
      alu_req.b     = seq64;
      ram_we        = 1'b0;
      ram_waddr     = ch_base + AW'(pick_ff);
      ram_wdata     = {hstart_ff, g_ff};
      ram_raddr     = ch_base + AW'(idx_ff);
      rd_valid_in   = valid_ff[ram_raddr];

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               ch_in    = req_channel;
               seq_in   = req_seq_nr;
               top_in   = highest_ff[req_channel];
               ok_in    = 1'b0;
               newer_in = 1'b0;
               split_in = 1'b0;
               state_in = ST_E1;
            end
         end
         // Extension: distance below the top, then the window floor.
         ST_E1: begin
            diff_in  = alu_rsp.res;
            ge_in    = alu_rsp.lt || (alu_rsp.res == '0);
            state_in = ST_E2;
         end
         ST_E2: begin
            alu_req.b = top_min;
            floor_in  = alu_rsp.res;
            state_in  = ST_E3;
         end
         ST_E3: begin
            alu_req.op = sngrf_pkg::ALU_ADD;
            alu_req.a  = seq64;
            alu_req.b  = diff_ff & sngrf_pkg::SPAN_MASK;
            if (ge_ff) begin
               g_in     = seq64;
               state_in = ST_C1;
            end else begin
               g_in     = alu_rsp.res;
               state_in = ST_E4;
            end
         end
         ST_E4: begin
            alu_req.a = g_ff;
            alu_req.b = floor_ff;
            state_in  = alu_rsp.lt ? ST_E5 : ST_C1;
         end
         ST_E5: begin
            alu_req.op = sngrf_pkg::ALU_ADD;
            alu_req.a  = g_ff;
            alu_req.b  = sngrf_pkg::SEQ_SPAN;
            g_in       = alu_rsp.res;
            state_in   = ST_C1;
         end
         // Classification: newer than the top, or a candidate for a gap.
         ST_C1: begin
            alu_req.a = top_ff;
            alu_req.b = g_ff;
            idx_in    = '0;
            if (alu_rsp.lt) begin
               newer_in = 1'b1;
               state_in = ST_C2;
            end else begin
               state_in = ST_S_RD;
            end
         end
         ST_C2: begin
            alu_req.op = sngrf_pkg::ALU_ADD;
            alu_req.b  = EW'(1);
            top1_in    = alu_rsp.res;
            state_in   = ST_C3;
         end
         ST_C3: begin
            alu_req.a = top1_ff;
            alu_req.b = g_ff;
            if (alu_rsp.lt) begin
               state_in = ST_C4;
            end else begin
               ok_in    = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_C4: begin
            alu_req.op = sngrf_pkg::ALU_ADD;
            alu_req.b  = thr64;
            diff_in    = alu_rsp.res;
            state_in   = ST_C5;
         end
         ST_C5: begin
            // A jump beyond the threshold drops all gaps of the channel.
            alu_req.a = diff_ff;
            alu_req.b = g_ff;
            if (alu_rsp.lt) begin
               for (int j = 0; j < DEPTH; j++) begin
                  if ((j >= GAPS_PER_CHANNEL) == ch_ff) begin
                     valid_in[j] = 1'b0;
                  end
               end
            end
            state_in = ST_P_RD;
         end
         // Victim search: first empty slot, else smallest seq_nr - start.
         ST_P_RD: begin
            state_in = ST_P_CK;
         end
         ST_P_CK: begin
            alu_req.a = seq64;
            alu_req.b = rd_start;
            cost_in   = alu_rsp.res;
            if (rd_start == rd_end) begin
               pick_in  = idx_ff;
               state_in = ST_P_DONE;
            end else begin
               state_in = ST_P_CMP;
            end
         end
         ST_P_CMP: begin
            alu_req.a = cost_ff;
            alu_req.b = best_ff;
            if ((idx_ff == '0) || alu_rsp.lt) begin
               best_in = cost_ff;
               pick_in = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_P_DONE;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_P_RD;
            end
         end
         ST_P_DONE: begin
            ram_we = 1'b1;
            valid_in[ram_waddr] = 1'b1;
            if (split_ff) begin
               ram_wdata = {hstart_ff, g_ff};
               state_in  = ST_W2;
            end else begin
               ram_wdata = {top1_ff, g_ff};
               ok_in     = 1'b1;
               state_in  = ST_OUT;
            end
         end
         ST_W2: begin
            // When the victim is the hit slot, its end keeps the split point.
            ram_we    = 1'b1;
            ram_waddr = ch_base + AW'(hit_ff);
            ram_wdata = {gx1_ff, (pick_ff == hit_ff) ? g_ff : hend_ff};
            valid_in[ram_waddr] = 1'b1;
            ok_in     = 1'b1;
            state_in  = ST_OUT;
         end
         // Gap search for an older number.
         ST_S_RD: begin
            state_in = ST_S_CK1;
         end
         ST_S_CK1: begin
            alu_req.a = g_ff;
            alu_req.b = rd_start;
            hstart_in = rd_start;
            hend_in   = rd_end;
            hit_in    = idx_ff;
            if (!alu_rsp.lt) begin
               state_in = ST_S_CK2;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_S_RD;
            end
         end
         ST_S_CK2: begin
            alu_req.a = g_ff;
            alu_req.b = hend_ff;
            if (alu_rsp.lt) begin
               state_in = ST_H1;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_S_RD;
            end
         end
         ST_H1: begin
            // A hit on the first element raises the start.
            alu_req.op = sngrf_pkg::ALU_ADD;
            alu_req.a  = g_ff;
            alu_req.b  = EW'(1);
            gx1_in     = alu_rsp.res;
            if (g_ff == hstart_ff) begin
               ram_we    = 1'b1;
               ram_waddr = ch_base + AW'(hit_ff);
               ram_wdata = {alu_rsp.res, hend_ff};
               ok_in     = 1'b1;
               state_in  = ST_OUT;
            end else begin
               state_in = ST_H2;
            end
         end
         ST_H2: begin
            // A hit on the last element lowers the end; else the gap splits.
            alu_req.a = hend_ff;
            alu_req.b = EW'(1);
            if (alu_rsp.res == g_ff) begin
               ram_we    = 1'b1;
               ram_waddr = ch_base + AW'(hit_ff);
               ram_wdata = {hstart_ff, g_ff};
               ok_in     = 1'b1;
               state_in  = ST_OUT;
            end else begin
               split_in = 1'b1;
               idx_in   = '0;
               state_in = ST_P_RD;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = ok_ff;
               rsp_ext_in   = g_ff;
               if (newer_ff) begin
                  highest_in[ch_ff] = g_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         highest_ff[0] <= '0;
         highest_ff[1] <= '0;
         thr_ff        <= sngrf_pkg::THRESHOLD_RESET;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         highest_ff[0] <= highest_in[0];
         highest_ff[1] <= highest_in[1];
         thr_ff        <= thr_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working registers of the item in flight and the output payload.
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      seq_ff      <= seq_in;
      top_ff      <= top_in;
      diff_ff     <= diff_in;
      ge_ff       <= ge_in;
      floor_ff    <= floor_in;
      g_ff        <= g_in;
      top1_ff     <= top1_in;
      idx_ff      <= idx_in;
      pick_ff     <= pick_in;
      hit_ff      <= hit_in;
      best_ff     <= best_in;
      cost_ff     <= cost_in;
      hstart_ff   <= hstart_in;
      hend_ff     <= hend_in;
      gx1_ff      <= gx1_in;
      split_ff    <= split_in;
      newer_ff    <= newer_in;
      ok_ff       <= ok_in;
      rd_valid_ff <= rd_valid_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_ext_ff  <= rsp_ext_in;
   end

endmodule
